// File: hdl/vga_pkg.sv
// package for the visibility gridding accumulator
// shared widths, item and queue types; no dependencies
`default_nettype none
package vga_pkg;
	localparam int GRID_SIDE = 256;
	localparam int ACC_BITS = 48;
	localparam int CELL_BITS = 2 * $clog2(GRID_SIDE);
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int DW = 20;
	localparam int SQW = 38;
	localparam int MAGW = 19;
	localparam int Q_BITS = 15;
	localparam int MEM_W = 3 * ACC_BITS;

	localparam logic REQ_ACC = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic req_type;
		logic signed [15:0] vis_a_re;
		logic signed [15:0] vis_a_im;
		logic signed [15:0] vis_b_re;
		logic signed [15:0] vis_b_im;
		logic signed [15:0] gain_a_re;
		logic signed [15:0] gain_a_im;
		logic signed [15:0] gain_b_re;
		logic signed [15:0] gain_b_im;
		logic take_conjugate;
		logic [7:0] grid_u;
		logic [7:0] grid_v;
	} vga_req_t;

	typedef struct packed {
		logic signed [15:0] cell_re;
		logic signed [15:0] cell_im;
		logic cell_empty;
	} vga_res_t;

	typedef struct packed {
		logic req_type;
		logic in_grid;
		logic [CELL_BITS-1:0] idx;
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic [MAGW-1:0] mag;
	} vga_work_t;
endpackage
`default_nettype wire

// File: hdl/vga_if.sv
// request and result channel interfaces
// depends on vga_pkg
`default_nettype none
interface vga_req_if;
	logic valid;
	logic ready;
	vga_pkg::vga_req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface vga_res_if;
	logic valid;
	logic ready;
	vga_pkg::vga_res_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/vga_front.sv
// front end: accepts items; for accumulate items forms the calibrated sum, rounds it and finds its magnitude
// depends on vga_pkg and vga_if
`default_nettype none
module vga_front (
	input wire logic clk,
	input wire logic arst_n,
	vga_req_if.sink req,
	output logic push_valid,
	input wire logic push_ready,
	output vga_pkg::vga_work_t push_data
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL = 3'd1;
	localparam logic [2:0] F_SUM = 3'd2;
	localparam logic [2:0] F_SQ = 3'd3;
	localparam logic [2:0] F_ADD = 3'd4;
	localparam logic [2:0] F_SQRT = 3'd5;
	localparam logic [2:0] F_PUSH = 3'd6;

	logic [2:0] state_q;
	vga_pkg::vga_req_t item_q;
	logic signed [31:0] p_q [8];
	logic signed [vga_pkg::DW-1:0] re_q, im_q;
	logic [vga_pkg::SQW-1:0] sqr_q, sqi_q;
	logic [vga_pkg::SQW-1:0] n_q, r_q, bit_q;
	logic signed [34:0] sre, sim, simc;
	logic signed [34:0] rre, rim;
	logic [vga_pkg::SQW:0] rb;
	logic in_grid;
	logic [31:0] idx_w;

	assign req.ready = (state_q == F_IDLE);
	assign sre = 35'(p_q[0]) - 35'(p_q[1]) + 35'(p_q[2]) - 35'(p_q[3]);
	assign sim = 35'(p_q[4]) + 35'(p_q[5]) + 35'(p_q[6]) + 35'(p_q[7]);
	assign simc = item_q.take_conjugate ? -sim : sim;
	assign rre = (sre + 35'sd8192) >>> 14;
	assign rim = (simc + 35'sd8192) >>> 14;
	assign rb = {1'b0, r_q} + {1'b0, bit_q};
	assign in_grid = (32'(item_q.grid_u) < vga_pkg::GRID_SIDE)
		&& (32'(item_q.grid_v) < vga_pkg::GRID_SIDE);
	assign idx_w = 32'(item_q.grid_u) * vga_pkg::GRID_SIDE + 32'(item_q.grid_v);

	assign push_valid = (state_q == F_PUSH);
	always_comb begin
		push_data.req_type = item_q.req_type;
		push_data.in_grid = in_grid;
		push_data.idx = idx_w[vga_pkg::CELL_BITS-1:0];
		push_data.re = re_q;
		push_data.im = im_q;
		push_data.mag = r_q[vga_pkg::MAGW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (req.valid) begin
					state_q <= (req.payload.req_type == vga_pkg::REQ_READ) ? F_PUSH : F_MUL;
				end
				F_MUL: state_q <= F_SUM;
				F_SUM: state_q <= F_SQ;
				F_SQ: state_q <= F_ADD;
				F_ADD: state_q <= F_SQRT;
				F_SQRT: if (bit_q == '0) begin
					state_q <= F_PUSH;
				end
				F_PUSH: if (push_ready) begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req.valid) begin
			item_q <= req.payload;
		end
		if (state_q == F_MUL) begin
			p_q[0] <= item_q.vis_a_re * item_q.gain_a_re;
			p_q[1] <= item_q.vis_a_im * item_q.gain_a_im;
			p_q[2] <= item_q.vis_b_re * item_q.gain_b_re;
			p_q[3] <= item_q.vis_b_im * item_q.gain_b_im;
			p_q[4] <= item_q.vis_a_re * item_q.gain_a_im;
			p_q[5] <= item_q.vis_a_im * item_q.gain_a_re;
			p_q[6] <= item_q.vis_b_re * item_q.gain_b_im;
			p_q[7] <= item_q.vis_b_im * item_q.gain_b_re;
		end
		if (state_q == F_SUM) begin
			re_q <= rre[vga_pkg::DW-1:0];
			im_q <= rim[vga_pkg::DW-1:0];
		end
		if (state_q == F_SQ) begin
			sqr_q <= vga_pkg::SQW'(40'(re_q * re_q));
			sqi_q <= vga_pkg::SQW'(40'(im_q * im_q));
		end
		if (state_q == F_ADD) begin
			n_q <= sqr_q + sqi_q;
			r_q <= '0;
			bit_q <= vga_pkg::SQW'(1) << (vga_pkg::SQW - 2);
		end
		if (state_q == F_SQRT && bit_q != '0) begin
			if ({1'b0, n_q} >= rb) begin
				n_q <= n_q - rb[vga_pkg::SQW-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

// File: hdl/vga_fifo.sv
// two-entry queue between front and back ends
// depends on vga_pkg
`default_nettype none
module vga_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire vga_pkg::vga_work_t push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output vga_pkg::vga_work_t pop_data
);
	vga_pkg::vga_work_t ent_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = ent_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// File: hdl/vga_back.sv
// back end: grid memory read-modify-write, normalising divide and result register
// depends on vga_pkg and vga_if
`default_nettype none
module vga_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire vga_pkg::vga_work_t pop_data,
	vga_res_if.source res
);
	localparam logic [2:0] B_CLR = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_EXEC = 3'd2;
	localparam logic [2:0] B_DIV = 3'd3;
	localparam int AB = vga_pkg::ACC_BITS;

	logic [2:0] state_q;
	logic [vga_pkg::CELL_BITS-1:0] clr_q;
	logic [vga_pkg::MEM_W-1:0] mem [vga_pkg::CELLS];
	logic [vga_pkg::MEM_W-1:0] rd_q;
	vga_pkg::vga_work_t cur_q;
	logic wr_en;
	logic [vga_pkg::CELL_BITS-1:0] wr_addr;
	logic [vga_pkg::MEM_W-1:0] wr_data;

	logic signed [AB-1:0] acc_re, acc_im;
	logic [AB-1:0] acc_n;
	logic signed [AB:0] s_re, s_im;
	logic [AB:0] s_n;
	logic [AB-1:0] new_re, new_im, new_n;
	logic [AB:0] mag_re, mag_im;
	logic [AB:0] rem_re_q, rem_im_q;
	logic [AB:0] tw_re, tw_im;
	logic neg_re_q, neg_im_q, sat_re_q, sat_im_q;
	logic [vga_pkg::Q_BITS-1:0] q_re_q, q_im_q;
	logic [3:0] step_q;
	logic out_valid_q;
	vga_pkg::vga_res_t out_q;
	logic take;
	logic [AB-1:0] smax, smin;

	assign smax = {1'b0, {(AB-1){1'b1}}};
	assign smin = {1'b1, {(AB-1){1'b0}}};
	assign acc_re = rd_q[3*AB-1:2*AB];
	assign acc_im = rd_q[2*AB-1:AB];
	assign acc_n = rd_q[AB-1:0];
	assign s_re = (AB+1)'(acc_re) + (AB+1)'(cur_q.re);
	assign s_im = (AB+1)'(acc_im) + (AB+1)'(cur_q.im);
	assign s_n = {1'b0, acc_n} + (AB+1)'(cur_q.mag);
	assign new_re = (s_re[AB] != s_re[AB-1]) ? (s_re[AB] ? smin : smax) : s_re[AB-1:0];
	assign new_im = (s_im[AB] != s_im[AB-1]) ? (s_im[AB] ? smin : smax) : s_im[AB-1:0];
	assign new_n = s_n[AB] ? {AB{1'b1}} : s_n[AB-1:0];
	assign mag_re = acc_re[AB-1] ? -{acc_re[AB-1], acc_re} : {1'b0, acc_re};
	assign mag_im = acc_im[AB-1] ? -{acc_im[AB-1], acc_im} : {1'b0, acc_im};
	assign tw_re = rem_re_q << 1;
	assign tw_im = rem_im_q << 1;

	assign take = (state_q == B_IDLE) && pop_valid
		&& (pop_data.req_type == vga_pkg::REQ_ACC || !out_valid_q);
	assign pop_ready = take;

	assign res.valid = out_valid_q;
	assign res.payload = out_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q.idx;
		wr_data = '0;
		unique case (state_q)
			B_CLR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			B_EXEC: begin
				if (cur_q.in_grid) begin
					if (cur_q.req_type == vga_pkg::REQ_ACC) begin
						wr_en = 1'b1;
						wr_data = {new_re, new_im, new_n};
					end else if (acc_n == '0) begin
						wr_en = 1'b1;
					end
				end
			end
			B_DIV: wr_en = (step_q == 4'(vga_pkg::Q_BITS));
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (take) begin
			rd_q <= mem[pop_data.idx];
			cur_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: if (take) begin
					state_q <= B_EXEC;
				end
				B_EXEC: begin
					if (cur_q.req_type == vga_pkg::REQ_READ) begin
						if (!cur_q.in_grid || acc_n == '0) begin
							out_valid_q <= 1'b1;
							state_q <= B_IDLE;
						end else begin
							state_q <= B_DIV;
						end
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_DIV: if (step_q == 4'(vga_pkg::Q_BITS)) begin
					out_valid_q <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_EXEC) begin
			if (cur_q.req_type == vga_pkg::REQ_READ) begin
				out_q <= '{cell_re: '0, cell_im: '0, cell_empty: 1'b1};
			end
			neg_re_q <= acc_re[AB-1];
			neg_im_q <= acc_im[AB-1];
			sat_re_q <= mag_re >= {1'b0, acc_n};
			sat_im_q <= mag_im >= {1'b0, acc_n};
			rem_re_q <= mag_re;
			rem_im_q <= mag_im;
			q_re_q <= '0;
			q_im_q <= '0;
			step_q <= '0;
		end
		if (state_q == B_DIV) begin
			if (step_q == 4'(vga_pkg::Q_BITS)) begin
				out_q.cell_empty <= 1'b0;
				out_q.cell_re <= sat_re_q ? (neg_re_q ? 16'sh8000 : 16'sh7fff)
					: (neg_re_q ? -16'({1'b0, q_re_q}) : 16'({1'b0, q_re_q}));
				out_q.cell_im <= sat_im_q ? (neg_im_q ? 16'sh8000 : 16'sh7fff)
					: (neg_im_q ? -16'({1'b0, q_im_q}) : 16'({1'b0, q_im_q}));
			end else begin
				step_q <= step_q + 1'b1;
				if (tw_re >= {1'b0, acc_n}) begin
					rem_re_q <= tw_re - {1'b0, acc_n};
					q_re_q <= {q_re_q[vga_pkg::Q_BITS-2:0], 1'b1};
				end else begin
					rem_re_q <= tw_re;
					q_re_q <= {q_re_q[vga_pkg::Q_BITS-2:0], 1'b0};
				end
				if (tw_im >= {1'b0, acc_n}) begin
					rem_im_q <= tw_im - {1'b0, acc_n};
					q_im_q <= {q_im_q[vga_pkg::Q_BITS-2:0], 1'b1};
				end else begin
					rem_im_q <= tw_im;
					q_im_q <= {q_im_q[vga_pkg::Q_BITS-2:0], 1'b0};
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/visibility_gridding_accumulator.sv
// visibility gridding accumulator: front end, two-entry queue, back end with grid memory
// an accumulate item: multiply, sum, square, add and the bit-pair square root in front, then one
// read-modify-write in back; a read item passes the front, then a 15-step divide in back
// if its cell holds data; front and back run concurrently; the front is ready only when idle
// after reset the back end clears the 65536-cell grid; items queue meanwhile
// depends on vga_pkg, vga_if, vga_front, vga_fifo, vga_back
`default_nettype none
module visibility_gridding_accumulator (
	input wire logic clk,
	input wire logic arst_n,
	vga_req_if.sink req,
	vga_res_if.source res
);
	logic f_valid, f_ready, b_valid, b_ready;
	vga_pkg::vga_work_t f_data, b_data;

	vga_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
	);

	vga_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
	);

	vga_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data), .res(res)
	);
endmodule
`default_nettype wire
